@@ hdl/sbcm_pkg.sv @@
`default_nettype none

package sbcm_pkg;

	// Geometry of the sprite and of the screen.
	localparam int TILE_SIZE   = 16;
	localparam int SCREEN_ROWS = 240;
	localparam int SCREEN_COLS = 320;
	localparam int MAX_TILES   = 16;

	// Field widths fixed by the interface.
	localparam int SIZE_W   = 5;
	localparam int ORIGIN_W = 11;
	localparam int COLOR_W  = 16;
	localparam int ROW_W    = 8;
	localparam int COL_W    = 9;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 16;

	// Largest tile count a size register can actually select.
	localparam int MAX_EFF = (MAX_TILES < (2 ** SIZE_W - 1)) ? MAX_TILES : (2 ** SIZE_W - 1);
	localparam int TC_W    = (MAX_EFF > 1) ? $clog2(MAX_EFF) : 1;
	localparam int PX_W    = $clog2(TILE_SIZE);
	localparam int POS_W   = $clog2(MAX_EFF * TILE_SIZE);
	localparam int COORD_W = ((POS_W > ORIGIN_W) ? POS_W : ORIGIN_W) + 2;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH       = 3'd0,
		REG_HEIGHT      = 3'd1,
		REG_ORIGIN_X    = 3'd2,
		REG_ORIGIN_Y    = 3'd3,
		REG_MIRROR      = 3'd4,
		REG_TRANSPARENT = 3'd5,
		REG_CLEAR_MODE  = 3'd6,
		REG_FILL_COLOR  = 3'd7
	} cfg_reg_t;

endpackage

`default_nettype wire

@@ hdl/sprite_blitter_clip_mirror.sv @@
// Sprite blitter with clipping, transparency and horizontal mirroring.
// Sprite pixels come in on the input channel (in_valid/in_ready) in storage
// order: tile by tile, then pixel row, then pixel column. Every input word
// gives exactly one output word (out_valid/out_ready): a screen row and
// column, a color, a write enable and a flag on the last pixel of the sprite.
// Setting first_pixel restarts the position counters at that pixel.
// Registers are written through cfg_valid/cfg_index/cfg_data, which is always
// ready; they must only change while no word is in flight.
// The datapath is two registers deep: the input stage holds the pixel and its
// tile and pixel position, the output register holds the finished write.
// An accepted word moves from the input stage to the output register, which
// drives out_valid. One word is taken every cycle while the receiver keeps
// out_ready high. When the receiver stalls, the output register holds its
// word and the input stage can still take one more word before in_ready
// falls.
// Reset empties both stages, clears the position counters and sets the
// registers to a one-by-one tile sprite at the origin in draw mode.

`default_nettype none

module sprite_blitter_clip_mirror (
	input  wire logic                             clk,
	input  wire logic                             arst_n,

	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [sbcm_pkg::IDX_W-1:0]       cfg_index,
	input  wire logic [sbcm_pkg::DATA_W-1:0]      cfg_data,

	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [sbcm_pkg::COLOR_W-1:0]     pixel_color,
	input  wire logic                             first_pixel,

	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  write_enable,
	output logic [sbcm_pkg::ROW_W-1:0]            screen_row,
	output logic [sbcm_pkg::COL_W-1:0]            screen_col,
	output logic [sbcm_pkg::COLOR_W-1:0]          write_color,
	output logic                                  last_pixel
);

	localparam int SW = sbcm_pkg::SIZE_W;
	localparam int TW = sbcm_pkg::TC_W;
	localparam int PW = sbcm_pkg::PX_W;
	localparam int CW = sbcm_pkg::COORD_W;
	localparam int OW = sbcm_pkg::ORIGIN_W;

	// Configuration registers.
	logic [SW-1:0]                     width_q;
	logic [SW-1:0]                     height_q;
	logic signed [OW-1:0]              origin_x_q;
	logic signed [OW-1:0]              origin_y_q;
	logic                              mirror_q;
	logic [sbcm_pkg::COLOR_W-1:0]      transparent_q;
	logic                              clear_mode_q;
	logic [sbcm_pkg::COLOR_W-1:0]      fill_color_q;

	// Position of the next pixel.
	logic [TW-1:0]                     tile_row_q;
	logic [TW-1:0]                     tile_col_q;
	logic [PW-1:0]                     pix_row_q;
	logic [PW-1:0]                     pix_col_q;

	// Input stage.
	logic                              valid_s1;
	logic [sbcm_pkg::COLOR_W-1:0]      color_s1;
	logic [TW-1:0]                     tile_row_s1;
	logic [TW-1:0]                     tile_col_s1;
	logic [PW-1:0]                     pix_row_s1;
	logic [PW-1:0]                     pix_col_s1;
	logic                              last_s1;

	// Output register.
	logic                              valid_q;
	logic                              we_q;
	logic [sbcm_pkg::ROW_W-1:0]        row_q;
	logic [sbcm_pkg::COL_W-1:0]        col_q;
	logic [sbcm_pkg::COLOR_W-1:0]      color_q;
	logic                              last_q;

	logic                              in_fire;
	logic                              out_adv;
	logic [SW-1:0]                     w_eff;
	logic [SW-1:0]                     h_eff;
	logic                              restart;
	logic [TW-1:0]                     tr_e, tc_e;
	logic [PW-1:0]                     pr_e, pc_e;
	logic                              pc_wrap, pr_wrap, tc_wrap, tr_wrap;
	logic [TW-1:0]                     tr_n, tc_n;
	logic [PW-1:0]                     pr_n, pc_n;
	logic [TW-1:0]                     tcol_c;
	logic [PW-1:0]                     pcol_c;
	logic [sbcm_pkg::POS_W-1:0]        row_pos_c, col_pos_c;
	logic [CW-1:0]                     row_c, col_c;
	logic                              on_screen_c;
	logic                              we_c;

	assign cfg_ready = 1'b1;
	assign out_adv   = !valid_q || out_ready;
	assign in_ready  = !valid_s1 || out_adv;
	assign in_fire   = in_valid && in_ready;

	// A size of zero counts as one; sizes beyond the tile limit are clamped.
	always_comb begin
		if (width_q == '0) begin
			w_eff = SW'(1);
		end else if (width_q > SW'(sbcm_pkg::MAX_EFF)) begin
			w_eff = SW'(sbcm_pkg::MAX_EFF);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = SW'(1);
		end else if (height_q > SW'(sbcm_pkg::MAX_EFF)) begin
			h_eff = SW'(sbcm_pkg::MAX_EFF);
		end else begin
			h_eff = height_q;
		end
	end

	// Position of the incoming pixel and the position that follows it.
	always_comb begin
		restart = first_pixel
			|| (SW'(tile_row_q) >= h_eff)
			|| (SW'(tile_col_q) >= w_eff)
			|| ({1'b0, pix_row_q} >= (PW+1)'(sbcm_pkg::TILE_SIZE))
			|| ({1'b0, pix_col_q} >= (PW+1)'(sbcm_pkg::TILE_SIZE));
		tr_e = restart ? '0 : tile_row_q;
		tc_e = restart ? '0 : tile_col_q;
		pr_e = restart ? '0 : pix_row_q;
		pc_e = restart ? '0 : pix_col_q;

		pc_wrap = (pc_e == PW'(sbcm_pkg::TILE_SIZE - 1));
		pr_wrap = (pr_e == PW'(sbcm_pkg::TILE_SIZE - 1));
		tc_wrap = (SW'(tc_e) == w_eff - SW'(1));
		tr_wrap = (SW'(tr_e) == h_eff - SW'(1));

		pc_n = pc_wrap ? '0 : pc_e + PW'(1);
		pr_n = pr_e;
		tc_n = tc_e;
		tr_n = tr_e;
		if (pc_wrap) begin
			pr_n = pr_wrap ? '0 : pr_e + PW'(1);
			if (pr_wrap) begin
				tc_n = tc_wrap ? '0 : tc_e + TW'(1);
				if (tc_wrap) begin
					tr_n = tr_wrap ? '0 : tr_e + TW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q       <= SW'(1);
			height_q      <= SW'(1);
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			mirror_q      <= 1'b0;
			transparent_q <= '0;
			clear_mode_q  <= 1'b0;
			fill_color_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (sbcm_pkg::cfg_reg_t'(cfg_index))
				sbcm_pkg::REG_WIDTH:       width_q       <= cfg_data[SW-1:0];
				sbcm_pkg::REG_HEIGHT:      height_q      <= cfg_data[SW-1:0];
				sbcm_pkg::REG_ORIGIN_X:    origin_x_q    <= cfg_data[OW-1:0];
				sbcm_pkg::REG_ORIGIN_Y:    origin_y_q    <= cfg_data[OW-1:0];
				sbcm_pkg::REG_MIRROR:      mirror_q      <= cfg_data[0];
				sbcm_pkg::REG_TRANSPARENT: transparent_q <= cfg_data[sbcm_pkg::COLOR_W-1:0];
				sbcm_pkg::REG_CLEAR_MODE:  clear_mode_q  <= cfg_data[0];
				sbcm_pkg::REG_FILL_COLOR:  fill_color_q  <= cfg_data[sbcm_pkg::COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_row_q <= '0;
			tile_col_q <= '0;
			pix_row_q  <= '0;
			pix_col_q  <= '0;
			valid_s1   <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (in_fire) begin
				tile_row_q <= tr_n;
				tile_col_q <= tc_n;
				pix_row_q  <= pr_n;
				pix_col_q  <= pc_n;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (out_adv) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			color_s1    <= pixel_color;
			tile_row_s1 <= tr_e;
			tile_col_s1 <= tc_e;
			pix_row_s1  <= pr_e;
			pix_col_s1  <= pc_e;
			last_s1     <= pc_wrap && pr_wrap && tc_wrap && tr_wrap;
		end
	end

	// Screen coordinates, clipping and transparency.
	always_comb begin
		tcol_c = mirror_q ? TW'(w_eff - SW'(1) - SW'(tile_col_s1)) : tile_col_s1;
		pcol_c = mirror_q ? PW'(sbcm_pkg::TILE_SIZE - 1) - pix_col_s1 : pix_col_s1;
		row_pos_c = sbcm_pkg::POS_W'(tile_row_s1) * sbcm_pkg::POS_W'(sbcm_pkg::TILE_SIZE)
			+ sbcm_pkg::POS_W'(pix_row_s1);
		col_pos_c = sbcm_pkg::POS_W'(tcol_c) * sbcm_pkg::POS_W'(sbcm_pkg::TILE_SIZE)
			+ sbcm_pkg::POS_W'(pcol_c);
		row_c = {{(CW-OW){origin_y_q[OW-1]}}, origin_y_q} + CW'(row_pos_c);
		col_c = {{(CW-OW){origin_x_q[OW-1]}}, origin_x_q} + CW'(col_pos_c);
		on_screen_c = !row_c[CW-1] && (row_c < CW'(sbcm_pkg::SCREEN_ROWS))
			&& !col_c[CW-1] && (col_c < CW'(sbcm_pkg::SCREEN_COLS));
		we_c = on_screen_c && (clear_mode_q || (color_s1 != transparent_q));
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			we_q    <= we_c;
			row_q   <= we_c ? row_c[sbcm_pkg::ROW_W-1:0] : '0;
			col_q   <= we_c ? col_c[sbcm_pkg::COL_W-1:0] : '0;
			color_q <= clear_mode_q ? fill_color_q : color_s1;
			last_q  <= last_s1;
		end
	end

	assign out_valid    = valid_q;
	assign write_enable = we_q;
	assign screen_row   = row_q;
	assign screen_col   = col_q;
	assign write_color  = color_q;
	assign last_pixel   = last_q;

	// An accepted word always lands in the input stage.
	assert property (@(posedge clk) disable iff (!arst_n) in_fire |=> valid_s1)
		else $error("accepted pixel did not reach the input stage");

	// A word in the input stage is not dropped while the output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_q && !out_ready |=> valid_s1 && valid_q)
		else $error("word lost during output stall");

	// Enabled writes always land on the screen.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && we_q |-> (row_q < sbcm_pkg::ROW_W'(sbcm_pkg::SCREEN_ROWS - 1)
			|| row_q == sbcm_pkg::ROW_W'(sbcm_pkg::SCREEN_ROWS - 1))
			&& (32'(col_q) < sbcm_pkg::SCREEN_COLS))
		else $error("enabled write outside the screen");

	// Pixel counters never leave the tile.
	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(pix_col_q) < sbcm_pkg::TILE_SIZE) && (32'(pix_row_q) < sbcm_pkg::TILE_SIZE))
		else $error("pixel counter outside the tile");

	// The last pixel of a sprite sends the counters back to the start.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && pc_wrap && pr_wrap && tc_wrap && tr_wrap |=>
		tile_row_q == '0 && tile_col_q == '0 && pix_row_q == '0 && pix_col_q == '0)
		else $error("counters did not wrap after the last pixel");

endmodule

`default_nettype wire
